FILE: hw/rtl/bcerp_pkg.sv
// bcerp_pkg: sizes, register codes, line store request type and the erosion kernel
// for the packed binary cross erosion block. no dependencies.
`timescale 1ns / 1ps

package bcerp_pkg;

  // image limits
  localparam int MAX_WIDTH     = 256;
  localparam int MAX_HEIGHT    = 4096;
  localparam int MIN_WIDTH     = 9;
  localparam int MIN_HEIGHT    = 3;
  localparam int ROW_BYTES_MAX = (MAX_WIDTH + 7) / 8;
  localparam int STORE_DEPTH   = 2 * ROW_BYTES_MAX;

  // derived widths
  localparam int COL_W   = $clog2(ROW_BYTES_MAX);
  localparam int NB_W    = $clog2(ROW_BYTES_MAX + 1);
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int WIDTH_W = 9;
  localparam int HEIGHT_W = 13;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = HEIGHT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH_PIXELS = 8'd0,
    CFG_HEIGHT_ROWS  = 8'd1
  } cfg_reg_t;

  // request to the line store, one per accepted byte
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [ADDR_W-1:0] up_addr;
    logic [ADDR_W-1:0] pf_addr;
  } ls_req_t;

  // cross erosion of one byte from its neighbourhood
  function automatic logic [7:0] erode_byte(
    input logic [7:0] left,
    input logic [7:0] mid,
    input logic [7:0] right,
    input logic [7:0] up,
    input logic [7:0] dn,
    input logic       first,
    input logic       last,
    input logic [7:0] edge_mask
  );
    logic [7:0] o;
    o = mid & {mid[6:0], 1'b1} & {1'b1, mid[7:1]} & up & dn;
    if (first || !left[0]) o[7] = 1'b0;
    if (last) o = o & edge_mask;
    else if (!right[7]) o[0] = 1'b0;
    return o;
  endfunction

endpackage

FILE: hw/rtl/bcerp_if.sv
// bcerp interfaces: pixel request channel, result channel and configuration write channel.
// depends on bcerp_pkg for field widths.
`timescale 1ns / 1ps

interface bcerp_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  modport source (output valid, output pixel_byte, input ready);
  modport sink   (input valid, input pixel_byte, output ready);
endinterface

interface bcerp_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] eroded_byte;
  logic       frame_end;
  logic       run_end;
  modport source (output valid, output eroded_byte, output frame_end, output run_end,
                  input ready);
  modport sink   (input valid, input eroded_byte, input frame_end, input run_end,
                  output ready);
endinterface

interface bcerp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bcerp_pkg::CFG_IDX_W-1:0]  index;
  logic [bcerp_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/binary_cross_erosion_packed.sv
// Packed binary 3x3 cross erosion. Takes one byte of eight pixels (bit 7 leftmost) per
// cycle in raster order and returns one eroded byte per input byte from the second row on,
// one row behind the input. The last byte of a frame is followed by a flush of the all-zero
// last row, width/8 (rounded up) bytes, one byte per cycle while the result side keeps
// up. Input is still taken during the flush, as the next frame's first row gives no
// results; the first byte of its second row waits in the input stage until the flush is
// done. Otherwise a byte is taken every cycle the result side keeps up. Each byte passes
// through one input stage, where the line store reads are registered, then the result
// register. The line store holds no reset values and needs no clearing; width and height
// writes restart the frame. Configuration writes are to be taken only while the block is
// idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module binary_cross_erosion_packed (
  input  logic              clk,
  input  logic              rst,
  bcerp_pix_if.sink         pix_in,
  bcerp_res_if.source       res_out,
  bcerp_cfg_if.sink         cfg
);

  // configuration registers
  logic [bcerp_pkg::WIDTH_W-1:0]  width_pixels;
  logic [bcerp_pkg::HEIGHT_W-1:0] height_rows;

  // frame position
  logic [bcerp_pkg::COL_W-1:0] col;
  logic [bcerp_pkg::ROW_W-1:0] row;
  logic [bcerp_pkg::COL_W-1:0] col_next;
  logic [bcerp_pkg::ROW_W-1:0] row_next;

  // effective geometry
  logic [bcerp_pkg::WIDTH_W-1:0]  w_eff;
  logic [bcerp_pkg::HEIGHT_W-1:0] h_eff;
  logic [bcerp_pkg::NB_W-1:0]     nb;
  logic [2:0]                     rest;
  logic [7:0]                     edge_mask;

  // current request position
  logic [bcerp_pkg::COL_W-1:0] x;
  logic [bcerp_pkg::ROW_W-1:0] y;
  logic                        x_first;
  logic                        x_last;
  logic                        frame_last;

  // input stage
  logic       s1_valid;
  logic [7:0] s1_dn;
  logic       s1_full;
  logic       s1_first;
  logic       s1_last;
  logic       s1_frame_last;
  logic [7:0] s1_edge_mask;
  logic [7:0] m_left;
  logic [7:0] m_cur;
  logic [7:0] up_data;
  logic [7:0] pf_data;
  logic [7:0] s1_result;

  // flush of the last row
  logic [bcerp_pkg::NB_W-1:0] flush_cnt;
  logic                       flushing;

  // handshake
  logic in_acc;
  logic cfg_acc;
  logic out_free;
  logic s1_go;
  logic flush_go;

  bcerp_pkg::ls_req_t ls_req;

  // geometry clamped to the supported range
  always_comb begin
    w_eff = width_pixels;
    if (width_pixels < bcerp_pkg::WIDTH_W'(bcerp_pkg::MIN_WIDTH))
      w_eff = bcerp_pkg::WIDTH_W'(bcerp_pkg::MIN_WIDTH);
    else if (width_pixels > bcerp_pkg::WIDTH_W'(bcerp_pkg::MAX_WIDTH))
      w_eff = bcerp_pkg::WIDTH_W'(bcerp_pkg::MAX_WIDTH);
    h_eff = height_rows;
    if (height_rows < bcerp_pkg::HEIGHT_W'(bcerp_pkg::MIN_HEIGHT))
      h_eff = bcerp_pkg::HEIGHT_W'(bcerp_pkg::MIN_HEIGHT);
    else if (height_rows > bcerp_pkg::HEIGHT_W'(bcerp_pkg::MAX_HEIGHT))
      h_eff = bcerp_pkg::HEIGHT_W'(bcerp_pkg::MAX_HEIGHT);
  end

  // bytes per row and mask of the last byte, clearing the padding and the rightmost valid pixel
  assign nb        = bcerp_pkg::NB_W'((w_eff + bcerp_pkg::WIDTH_W'(7)) >> 3);
  assign rest      = 3'd0 - w_eff[2:0];
  assign edge_mask = 8'hFF << ({1'b0, rest} + 4'd1);

  // position of the byte on offer
  always_comb begin
    x = col;
    if ({1'b0, col} >= nb) x = '0;
    y = row;
    if ({1'b0, row} >= h_eff) y = '0;
    x_first    = (x == '0);
    x_last     = ({1'b0, x} == nb - bcerp_pkg::NB_W'(1));
    frame_last = x_last && ({1'b0, y} == h_eff - bcerp_pkg::HEIGHT_W'(1));
  end

  // position after this byte
  always_comb begin
    col_next = x + bcerp_pkg::COL_W'(1);
    row_next = y;
    if (frame_last) begin
      col_next = '0;
      row_next = '0;
    end else if (x_last) begin
      col_next = '0;
      row_next = y + bcerp_pkg::ROW_W'(1);
    end
  end

  // handshake control
  assign flushing  = (flush_cnt != '0);
  assign out_free  = !res_out.valid || res_out.ready;
  assign s1_go     = s1_valid && out_free && !flushing;
  assign flush_go  = flushing && out_free;
  assign pix_in.ready = !rst && (!s1_valid || s1_go);
  assign cfg.ready    = !rst;
  assign in_acc    = pix_in.valid && pix_in.ready;
  assign cfg_acc   = cfg.valid && cfg.ready;

  // line store request: the upper byte and the next byte of the middle row;
  // at the row end the prefetch fetches byte zero of this row for the next one
  always_comb begin
    ls_req.en      = in_acc;
    ls_req.wr_addr = {y[0], x};
    ls_req.wr_data = pix_in.pixel_byte;
    ls_req.up_addr = {y[0], x};
    ls_req.pf_addr = x_last ? {y[0], bcerp_pkg::COL_W'(0)}
                            : {~y[0], x + bcerp_pkg::COL_W'(1)};
  end

  bcerp_line_store u_line_store (
    .clk     (clk),
    .req     (ls_req),
    .up_data (up_data),
    .pf_data (pf_data)
  );

  // width and height writes restart the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      width_pixels <= bcerp_pkg::WIDTH_W'(bcerp_pkg::MAX_WIDTH);
      height_rows  <= bcerp_pkg::HEIGHT_W'(480);
      col          <= '0;
      row          <= '0;
    end else if (cfg_acc) begin
      case (cfg.index)
        bcerp_pkg::CFG_WIDTH_PIXELS: begin
          width_pixels <= cfg.data[bcerp_pkg::WIDTH_W-1:0];
          col          <= '0;
          row          <= '0;
        end
        bcerp_pkg::CFG_HEIGHT_ROWS: begin
          height_rows <= cfg.data;
          col         <= '0;
          row         <= '0;
        end
        default: ;
      endcase
    end else if (in_acc) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // input stage valid: rows from the second on give a result
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= (y != '0);
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // input stage payload and middle row window
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_dn         <= pix_in.pixel_byte;
      s1_full       <= (y > bcerp_pkg::ROW_W'(1));
      s1_first      <= x_first;
      s1_last       <= x_last;
      s1_frame_last <= frame_last;
      s1_edge_mask  <= edge_mask;
      m_cur         <= pf_data;
      m_left        <= m_cur;
    end
  end

  // eroded byte, zero on the first output row
  assign s1_result = s1_full
    ? bcerp_pkg::erode_byte(m_left, m_cur, pf_data, up_data, s1_dn,
                            s1_first, s1_last, s1_edge_mask)
    : 8'h00;

  // flush counter for the zero last row
  always_ff @(posedge clk) begin
    if (rst) begin
      flush_cnt <= '0;
    end else if (flush_go) begin
      flush_cnt <= flush_cnt - bcerp_pkg::NB_W'(1);
    end else if (s1_go && s1_frame_last) begin
      flush_cnt <= nb;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_out.valid <= 1'b0;
    end else if (out_free) begin
      res_out.valid <= flush_go || s1_go;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (flush_go) begin
      res_out.eroded_byte <= 8'h00;
      res_out.frame_end   <= (flush_cnt == bcerp_pkg::NB_W'(1));
      res_out.run_end     <= (flush_cnt == bcerp_pkg::NB_W'(1));
    end else if (s1_go) begin
      res_out.eroded_byte <= s1_result;
      res_out.frame_end   <= 1'b0;
      res_out.run_end     <= !s1_frame_last;
    end
  end

endmodule

FILE: hw/rtl/bcerp_line_store.sv
// bcerp_line_store: two rows of packed bytes, one write and two registered reads per request.
// depends on bcerp_pkg.
`timescale 1ns / 1ps

module bcerp_line_store (
  input  logic               clk,
  input  bcerp_pkg::ls_req_t req,
  output logic [7:0]         up_data,
  output logic [7:0]         pf_data
);

  logic [7:0] mem [bcerp_pkg::STORE_DEPTH];

  // read before write: the upper row byte is read at the address being replaced
  always_ff @(posedge clk) begin
    if (req.en) begin
      mem[req.wr_addr] <= req.wr_data;
      up_data          <= mem[req.up_addr];
      pf_data          <= mem[req.pf_addr];
    end
  end

endmodule

FILE: hw/rtl/bcerp_checker.sv
// bcerp_checker: port level checks of the packed erosion block, bound to the top level.
// depends on the top level's channel ports.
`timescale 1ns / 1ps

module bcerp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_frame_end,
  input logic       out_run_end
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_frame_end)
                                && $stable(out_run_end))
    else $error("result payload changed while stalled");

  // the frame end byte also closes its request's run
  a_frame_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_frame_end |-> out_run_end)
    else $error("frame end without run end");

  // the last row is all zero, so the frame end byte is zero
  a_frame_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_frame_end |-> out_byte == 8'h00)
    else $error("frame end byte not zero");

  // nothing offered straight after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered after reset");

endmodule

bind binary_cross_erosion_packed bcerp_checker u_bcerp_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (res_out.valid),
  .out_ready     (res_out.ready),
  .out_byte      (res_out.eroded_byte),
  .out_frame_end (res_out.frame_end),
  .out_run_end   (res_out.run_end)
);

FILE: sim/tb.sv
// tb: self-checking bench for binary_cross_erosion_packed, the packed 3x3 cross erosion.
// predicts every eroded byte, frame end and run end from its own row store copy.
// depends on bcerp_pkg, the bcerp interfaces and the block itself.
`timescale 1ns / 1ps

module tb;
  import bcerp_pkg::*;

  // register indexes outside the list, which the block ignores
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_SPARE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_TOP   = 8'd255;

  // cycles the pipeline may still be busy after the last result
  localparam int PIPE_LAT   = 8;
  // cycles with no accepted request before the run is abandoned
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 80;

  typedef struct packed {
    logic [7:0] pixels;
    logic       frame_end;
    logic       run_end;
  } erosion_t;

  logic clk;
  logic rst;

  bcerp_pix_if pix ();
  bcerp_res_if res ();
  bcerp_cfg_if cfg_bus ();

  binary_cross_erosion_packed dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix),
    .res_out (res),
    .cfg     (cfg_bus)
  );

  // predicted state of the block
  logic [7:0] line_mem [0:STORE_DEPTH-1];
  int         col_pos;
  int         row_pos;
  int         img_width;
  int         img_height;

  erosion_t   erosion_due [$];
  int         err_count = 0;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         rand_sent;
  int         quiet_cycles = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mismatch reporting
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // expected results for one accepted pixel byte
  function automatic void predict_erosion(input logic [7:0] dn);
    int w, h, nb, x, y, cur, prv, rest;
    logic [7:0] mid, up, o;
    erosion_t fresh [$];
    erosion_t r;
    w = img_width;
    if (w < MIN_WIDTH) w = MIN_WIDTH;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = img_height;
    if (h < MIN_HEIGHT) h = MIN_HEIGHT;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    nb = (w + 7) / 8;
    x = (col_pos >= nb) ? 0 : col_pos;
    y = (row_pos >= h) ? 0 : row_pos;
    cur = (y % 2) * ROW_BYTES_MAX;
    prv = ((y + 1) % 2) * ROW_BYTES_MAX;

    // output row y-1, zero for the top border row
    if (y >= 1) begin
      o = 8'h00;
      if (y >= 2) begin
        mid = line_mem[prv + x];
        up  = line_mem[cur + x];
        o = mid & {mid[6:0], 1'b1} & {1'b1, mid[7:1]} & up & dn;
        if (x == 0) begin
          o[7] = 1'b0;
        end else if (!line_mem[prv + x - 1][0]) begin
          o[7] = 1'b0;
        end
        if (x + 1 < nb) begin
          if (!line_mem[prv + x + 1][7]) o[0] = 1'b0;
        end else begin
          // clear the padding and the rightmost valid pixel
          rest = 8 * nb - w;
          o = o & (8'hFF << (rest + 1));
        end
      end
      r = '{pixels: o, frame_end: 1'b0, run_end: 1'b0};
      fresh.push_back(r);
    end

    line_mem[cur + x] = dn;

    // last byte of the frame flushes the zero bottom row
    if (y == h - 1 && x == nb - 1) begin
      for (int i = 0; i < nb; i++) begin
        r = '{pixels: 8'h00, frame_end: (i == nb - 1), run_end: 1'b0};
        fresh.push_back(r);
      end
      col_pos = 0;
      row_pos = 0;
    end else if (x + 1 < nb) begin
      col_pos = x + 1;
      row_pos = y;
    end else begin
      col_pos = 0;
      row_pos = y + 1;
    end

    if (fresh.size() > 0) fresh[fresh.size() - 1].run_end = 1'b1;
    foreach (fresh[i]) erosion_due.push_back(fresh[i]);
  endfunction

  task automatic set_idle(input int snd, input int rcv);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
  endtask

  // one configuration request, valid left high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (idx == CFG_WIDTH_PIXELS) begin
      img_width = val[WIDTH_W-1:0];
      col_pos = 0;
      row_pos = 0;
    end else if (idx == CFG_HEIGHT_ROWS) begin
      img_height = val;
      col_pos = 0;
      row_pos = 0;
    end
  endtask

  task automatic end_cfg();
    cfg_bus.valid <= 1'b0;
  endtask

  // one pixel request with random gaps in front
  task automatic send_pixels(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid      <= 1'b1;
    pix.pixel_byte <= b;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    predict_erosion(b);
  endtask

  // hold off until every expected result is back
  task automatic drain_results();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (erosion_due.size() != 0) @(posedge clk);
  endtask

  // drained and the pipeline settled, safe for register writes
  task automatic wait_idle();
    drain_results();
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  // solid frame at the narrowest width: only the border is cleared
  task automatic test_solid_frame();
    wait_idle();
    write_reg(CFG_WIDTH_PIXELS, 13'd9);
    write_reg(CFG_HEIGHT_ROWS, 13'd3);
    end_cfg();
    repeat (6) send_pixels(8'hFF);
  endtask

  // width a multiple of eight, height below range
  task automatic test_exact_width();
    wait_idle();
    write_reg(CFG_HEIGHT_ROWS, 13'd1);
    write_reg(CFG_WIDTH_PIXELS, 13'd16);
    end_cfg();
    repeat (6) send_pixels(8'hFF);
  endtask

  // width field zero with high data bits set, height far above range
  task automatic test_clamped_sizes();
    wait_idle();
    write_reg(CFG_WIDTH_PIXELS, 13'h1E00);
    write_reg(CFG_HEIGHT_ROWS, 13'h1FFF);
    end_cfg();
    send_pixels(8'h00);
    send_pixels(8'hFF);
    send_pixels(8'h80);
    send_pixels(8'h01);
  endtask

  // writes to unknown indexes in mid frame must not restart it
  task automatic test_unused_index();
    wait_idle();
    write_reg(CFG_WIDTH_PIXELS, 13'd9);
    write_reg(CFG_HEIGHT_ROWS, 13'd3);
    end_cfg();
    send_pixels(8'hFF);
    send_pixels(8'hFF);
    send_pixels(8'hFE);
    wait_idle();
    write_reg(CFG_INDEX_SPARE, 13'($urandom));
    write_reg(CFG_INDEX_TOP, 13'($urandom));
    end_cfg();
    send_pixels(8'hFF);
    send_pixels(8'h7F);
    send_pixels(8'hC0);
  endtask

  // widest frame, width above range, mostly set pixels
  task automatic test_wide_frame();
    wait_idle();
    write_reg(CFG_WIDTH_PIXELS, 13'd511);
    write_reg(CFG_HEIGHT_ROWS, 13'd3);
    end_cfg();
    for (int i = 0; i < 96; i++) begin
      send_pixels(($urandom_range(99) < 80) ? 8'hFF : 8'($urandom));
    end
  endtask

  // random frames, mostly whole, some cut short by a register write
  task automatic run_random_frames(input int target);
    int total, n, dens, wsel, hsel, w, h, nb;
    bit keep, partial;
    logic [CFG_DATA_W-1:0] wv, hv;
    keep = 1'b0;
    while (rand_sent < target) begin
      if (rand_sent < target / 3) set_idle(14, 53);
      else if (rand_sent < 2 * target / 3) set_idle(53, 14);
      else set_idle(0, 0);

      if (!keep) begin
        wait_idle();
        wsel = $urandom_range(19);
        if (wsel == 0) wv = 13'd256;
        else if (wsel == 1) wv = 13'($urandom_range(257, 511));
        else if (wsel == 2) wv = 13'($urandom_range(0, 8));
        else wv = 13'($urandom_range(9, 40));
        hsel = $urandom_range(19);
        if (hsel == 0) hv = 13'h1FFF;
        else if (hsel == 1) hv = 13'd4096;
        else if (hsel <= 3) hv = 13'($urandom_range(0, 2));
        else hv = 13'($urandom_range(3, 5));
        write_reg(CFG_WIDTH_PIXELS, wv);
        write_reg(CFG_HEIGHT_ROWS, hv);
        end_cfg();
      end

      w = img_width;
      if (w < MIN_WIDTH) w = MIN_WIDTH;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = img_height;
      if (h < MIN_HEIGHT) h = MIN_HEIGHT;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      nb = (w + 7) / 8;
      total = nb * h;

      // long frames are cut after a few rows
      partial = (h > 5) || (nb > 8) || ($urandom_range(99) < 15);
      if (h > 5 || nb > 8) n = $urandom_range(nb + 1, 3 * nb);
      else if (partial) n = $urandom_range(1, total - 1);
      else n = total;

      dens = $urandom_range(50, 95);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) < 2) drain_results();
        send_pixels(($urandom_range(99) < dens) ? 8'hFF : 8'($urandom));
        rand_sent++;
      end
      keep = !partial && ($urandom_range(2) == 0);
    end
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checking against the oldest expectation
  always @(posedge clk) begin
    erosion_t want;
    if (!rst && res.valid && res.ready) begin
      if (erosion_due.size() == 0) begin
        report_mismatch("result with nothing pending", res.eroded_byte, 0);
      end else begin
        want = erosion_due.pop_front();
        if (res.eroded_byte !== want.pixels)
          report_mismatch("eroded_byte", res.eroded_byte, want.pixels);
        if (res.frame_end !== want.frame_end)
          report_mismatch("frame_end", res.frame_end, want.frame_end);
        if (res.run_end !== want.run_end)
          report_mismatch("run_end", res.run_end, want.run_end);
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[binary_cross_erosion_packed] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // test sequence
  initial begin
    rst            <= 1'b1;
    pix.valid      <= 1'b0;
    pix.pixel_byte <= 8'h00;
    cfg_bus.valid  <= 1'b0;
    cfg_bus.index  <= CFG_WIDTH_PIXELS;
    cfg_bus.data   <= '0;
    rand_sent      = 0;
    col_pos        = 0;
    row_pos        = 0;
    img_width      = MAX_WIDTH;
    img_height     = 480;
    foreach (line_mem[i]) line_mem[i] = 8'h00;
    set_idle(14, 53);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_solid_frame();
    test_exact_width();
    test_clamped_sizes();
    test_unused_index();
    test_wide_frame();
    run_random_frames(RANDOM_ITEMS);

    drain_results();
    repeat (PIPE_LAT) @(posedge clk);
    if (err_count == 0) begin
      $display("[binary_cross_erosion_packed] OK");
    end else begin
      $display("[binary_cross_erosion_packed] ERROR");
    end
    $finish;
  end

endmodule

FILE: binary_cross_erosion_packed.f
hw/rtl/bcerp_pkg.sv
hw/rtl/bcerp_if.sv
hw/rtl/bcerp_line_store.sv
hw/rtl/binary_cross_erosion_packed.sv
hw/rtl/bcerp_checker.sv
sim/tb.sv
